/* rtl/pbe_pkg.sv */
// shared constants, types and arithmetic helpers for the billboard expander
package pbe_pkg;

  // pool and frame limits
  localparam int POOL_SLOTS = 4096;
  localparam int QUAD_LIMIT = 4096;
  localparam int ADDR_W     = $clog2(POOL_SLOTS);
  localparam int QCNT_W     = $clog2(QUAD_LIMIT + 1);

  // vector component width entering the normalizer (33-bit differences)
  localparam int CW = 33;

  // hint too short below 1.0e-8 in Q4.60
  localparam logic [63:0] RIGHT_EPS_Q60 = 64'd11529215046;

  // configuration register indexes
  localparam logic [1:0] CFG_CAM_X = 2'd0;
  localparam logic [1:0] CFG_CAM_Y = 2'd1;
  localparam logic [1:0] CFG_CAM_Z = 2'd2;

  // status of the normalizer
  typedef struct packed {
    logic done;
    logic ok;
  } unit_rsp_t;

  // round a Q.60 product to Q.30, ties away from zero
  function automatic logic signed [63:0] round30(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    r = (m + 64'd536870912) >> 30;
    round30 = v[63] ? -$signed(r) : $signed(r);
  endfunction

  // clamp to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

/* rtl/pbe_unit3.sv */
// iterative vector normalizer: shift, sum of squares, bitwise sqrt, restoring divide
module pbe_unit3 (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [pbe_pkg::CW-1:0] c_x,
  input  logic signed [pbe_pkg::CW-1:0] c_y,
  input  logic signed [pbe_pkg::CW-1:0] c_z,
  output pbe_pkg::unit_rsp_t           rsp,
  output logic signed [31:0]           u_x,
  output logic signed [31:0]           u_y,
  output logic signed [31:0]           u_z
);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_NORM = 3'd1;
  localparam logic [2:0] U_SQ   = 3'd2;
  localparam logic [2:0] U_SQRT = 3'd3;
  localparam logic [2:0] U_DIV  = 3'd4;
  localparam int CW_TOP = pbe_pkg::CW - 1;

  logic [2:0]  state_r;
  logic [32:0] m_r [3];
  logic        neg_r [3];
  logic [1:0]  idx_r;
  logic [4:0]  cnt_r;
  logic [62:0] sum_r;
  logic [62:0] res_r;
  logic [31:0] len_r;
  logic [31:0] rem_r;
  logic [30:0] dv_r;
  logic [30:0] q_r;
  logic [31:0] u_r [3];
  logic        done_r;
  logic        ok_r;

  // magnitudes of the incoming vector
  logic [32:0] ma_x, ma_y, ma_z;
  assign ma_x = c_x[CW_TOP] ? (33'd0 - 33'(c_x)) : 33'(c_x);
  assign ma_y = c_y[CW_TOP] ? (33'd0 - 33'(c_y)) : 33'(c_y);
  assign ma_z = c_z[CW_TOP] ? (33'd0 - 33'(c_z)) : 33'(c_z);

  // largest component for the normalizing shift
  logic [32:0] mx;
  always_comb begin
    mx = m_r[0];
    if (m_r[1] > mx) mx = m_r[1];
    if (m_r[2] > mx) mx = m_r[2];
  end

  // shared datapath pieces
  logic [59:0] sq;
  logic [62:0] bitv;
  logic [62:0] trial;
  logic [32:0] dtry;
  logic [30:0] qn;
  logic        qbit;
  assign sq    = 60'(m_r[idx_r][29:0]) * 60'(m_r[idx_r][29:0]);
  assign bitv  = 63'd1 << {cnt_r, 1'b0};
  assign trial = res_r + bitv;
  assign dtry  = {rem_r, dv_r[30]};
  assign qbit  = (dtry >= {1'b0, len_r});
  assign qn    = {q_r[29:0], qbit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
      ok_r    <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        U_IDLE: begin
          if (start) begin
            m_r[0]  <= ma_x;
            m_r[1]  <= ma_y;
            m_r[2]  <= ma_z;
            neg_r[0] <= c_x[CW_TOP];
            neg_r[1] <= c_y[CW_TOP];
            neg_r[2] <= c_z[CW_TOP];
            if (ma_x == 33'd0 && ma_y == 33'd0 && ma_z == 33'd0) begin
              done_r <= 1'b1;
              ok_r   <= 1'b0;
            end else begin
              state_r <= U_NORM;
            end
          end
        end
        // bring the largest magnitude to exactly 30 bits
        U_NORM: begin
          if (mx[32:30] != 3'd0) begin
            m_r[0] <= m_r[0] >> 1;
            m_r[1] <= m_r[1] >> 1;
            m_r[2] <= m_r[2] >> 1;
          end else if (!mx[29]) begin
            m_r[0] <= m_r[0] << 1;
            m_r[1] <= m_r[1] << 1;
            m_r[2] <= m_r[2] << 1;
          end else begin
            state_r <= U_SQ;
            idx_r   <= 2'd0;
            sum_r   <= '0;
          end
        end
        // sum of squares, one component a cycle
        U_SQ: begin
          sum_r <= sum_r + 63'(sq);
          if (idx_r == 2'd2) begin
            state_r <= U_SQRT;
            cnt_r   <= 5'd31;
            res_r   <= '0;
          end else begin
            idx_r <= idx_r + 2'd1;
          end
        end
        // floor square root, one result bit a cycle
        U_SQRT: begin
          if (sum_r >= trial) begin
            sum_r <= sum_r - trial;
            res_r <= (res_r >> 1) + bitv;
          end else begin
            res_r <= res_r >> 1;
          end
          if (cnt_r == 5'd0) begin
            state_r <= U_DIV;
            len_r   <= (sum_r >= trial) ? 32'((res_r >> 1) + bitv) : 32'(res_r >> 1);
            idx_r   <= 2'd0;
            cnt_r   <= 5'd30;
            rem_r   <= m_r[0][32:1];
            dv_r    <= {m_r[0][0], 30'd0};
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        // mag * 2^30 / len, one quotient bit a cycle
        U_DIV: begin
          rem_r <= qbit ? 32'(dtry - {1'b0, len_r}) : dtry[31:0];
          dv_r  <= dv_r << 1;
          q_r   <= qn;
          if (cnt_r == 5'd0) begin
            u_r[idx_r] <= neg_r[idx_r] ? (32'd0 - 32'(qn)) : 32'(qn);
            if (idx_r == 2'd2) begin
              state_r <= U_IDLE;
              done_r  <= 1'b1;
              ok_r    <= 1'b1;
            end else begin
              idx_r <= idx_r + 2'd1;
              cnt_r <= 5'd30;
              rem_r <= m_r[idx_r + 2'd1][32:1];
              dv_r  <= {m_r[idx_r + 2'd1][0], 30'd0};
            end
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.ok   = ok_r;
  assign u_x = u_r[0];
  assign u_y = u_r[1];
  assign u_z = u_r[2];

endmodule

/* rtl/particle_billboard_expander_core.sv */
// billboard expander top level: slot stores, sequencer, shared multiplier, corner output
// a dead slot or a slot over the frame quad limit is done once it is accepted; the sequencer stays idle
// an alive slot is slower under output stalls; it takes two normalizer passes
// (up to ~30 shift steps, 3 squares, 32 sqrt steps, 93 divide steps), 12 multiply steps
// on the shared multiplier, then four corner requests, each held until out_ready
// after reset a pass over all 4096 slots clears the previous-center valid store; no request is taken meanwhile
module particle_billboard_expander_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_slot_index,
  input  logic        in_alive,
  input  logic        in_frame_start,
  input  logic [31:0] in_center_x,
  input  logic [31:0] in_center_y,
  input  logic [31:0] in_center_z,
  input  logic [30:0] in_half_size,
  input  logic [15:0] in_color_r,
  input  logic [15:0] in_color_g,
  input  logic [15:0] in_color_b,
  input  logic [15:0] in_color_a,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_vert_x,
  output logic [31:0] out_vert_y,
  output logic [31:0] out_vert_z,
  output logic [31:0] out_prev_x,
  output logic [31:0] out_prev_y,
  output logic [31:0] out_prev_z,
  output logic [1:0]  out_corner,
  output logic [15:0] out_out_r,
  output logic [15:0] out_out_g,
  output logic [15:0] out_out_b,
  output logic [15:0] out_out_a,
  output logic        out_quad_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = pbe_pkg::ADDR_W;
  localparam int QW = pbe_pkg::QCNT_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FWD   = 4'd2;
  localparam logic [3:0] S_WF    = 4'd3;
  localparam logic [3:0] S_HINT  = 4'd4;
  localparam logic [3:0] S_HCHK  = 4'd5;
  localparam logic [3:0] S_RST   = 4'd6;
  localparam logic [3:0] S_WR    = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0]  state_r;
  logic [AW-1:0] clr_r;
  logic [QW-1:0] quads_r;
  logic [31:0] cam_r [3];

  // latched request
  logic [AW-1:0] addr_r;
  logic        in_pool_r;
  logic [31:0] pos_r [3];
  logic [30:0] size_r;
  logic [15:0] col_r [4];

  // slot stores
  logic [31:0] px_mem [pbe_pkg::POOL_SLOTS];
  logic [31:0] py_mem [pbe_pkg::POOL_SLOTS];
  logic [31:0] pz_mem [pbe_pkg::POOL_SLOTS];
  logic        vld_mem [pbe_pkg::POOL_SLOTS];
  logic [31:0] prd_r [3];
  logic        vrd_r;
  logic [31:0] prv_r [3];

  // geometry
  logic signed [31:0] f_r [3];
  logic signed [31:0] r_r [3];
  logic signed [31:0] up_r [3];
  logic signed [32:0] re_r [3];
  logic signed [32:0] ue_r [3];
  logic signed [63:0] acc_r;
  logic        hint_z_r;
  logic [3:0]  step_r;
  logic [1:0]  corner_r;

  // normalizer
  logic        u_start;
  logic signed [pbe_pkg::CW-1:0] ucx, ucy, ucz;
  pbe_pkg::unit_rsp_t u_rsp;
  logic signed [31:0] uo_x, uo_y, uo_z;

  pbe_unit3 u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (u_start),
    .c_x   (ucx),
    .c_y   (ucy),
    .c_z   (ucz),
    .rsp   (u_rsp),
    .u_x   (uo_x),
    .u_y   (uo_y),
    .u_z   (uo_z)
  );

  // handshakes
  logic in_acc;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_EMIT);

  logic [16:0]   slot_ext;
  logic          in_pool;
  logic [AW-1:0] in_addr;
  logic [QW-1:0] q_eff;
  assign slot_ext = {5'd0, in_slot_index};
  assign in_pool  = (slot_ext < 17'(pbe_pkg::POOL_SLOTS));
  assign in_addr  = slot_ext[AW-1:0];
  assign q_eff    = in_frame_start ? '0 : quads_r;

  // normalizer operands: forward from the camera difference, right from the hint
  always_comb begin
    if (state_r == S_FWD) begin
      ucx = 33'({cam_r[0][31], cam_r[0]}) - 33'({pos_r[0][31], pos_r[0]});
      ucy = 33'({cam_r[1][31], cam_r[1]}) - 33'({pos_r[1][31], pos_r[1]});
      ucz = 33'({cam_r[2][31], cam_r[2]}) - 33'({pos_r[2][31], pos_r[2]});
    end else if (!hint_z_r) begin
      ucx = 33'(f_r[2]);
      ucy = '0;
      ucz = -33'(f_r[0]);
    end else begin
      ucx = -33'(f_r[1]);
      ucy = 33'(f_r[0]);
      ucz = '0;
    end
  end
  assign u_start = (state_r == S_FWD) || (state_r == S_RST);

  // shared multiplier operand select
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [31:0] sz;
  assign sz = $signed({1'b0, size_r});
  always_comb begin
    ma = f_r[0];
    mb = f_r[0];
    if (state_r == S_HINT) begin
      case ({hint_z_r, step_r[0]})
        2'b00:   begin ma = f_r[0]; mb = f_r[0]; end
        2'b01:   begin ma = f_r[2]; mb = f_r[2]; end
        2'b10:   begin ma = f_r[1]; mb = f_r[1]; end
        default: begin ma = f_r[0]; mb = f_r[0]; end
      endcase
    end else begin
      case (step_r)
        4'd0:    begin ma = f_r[1];  mb = r_r[2]; end
        4'd1:    begin ma = f_r[2];  mb = r_r[1]; end
        4'd2:    begin ma = f_r[2];  mb = r_r[0]; end
        4'd3:    begin ma = f_r[0];  mb = r_r[2]; end
        4'd4:    begin ma = f_r[0];  mb = r_r[1]; end
        4'd5:    begin ma = f_r[1];  mb = r_r[0]; end
        4'd6:    begin ma = r_r[0];  mb = sz; end
        4'd7:    begin ma = r_r[1];  mb = sz; end
        4'd8:    begin ma = r_r[2];  mb = sz; end
        4'd9:    begin ma = up_r[0]; mb = sz; end
        4'd10:   begin ma = up_r[1]; mb = sz; end
        default: begin ma = up_r[2]; mb = sz; end
      endcase
    end
  end
  assign prod = ma * mb;

  logic signed [63:0] diff;
  logic signed [63:0] rdiff;
  logic signed [63:0] rprod;
  assign diff  = acc_r - prod;
  assign rdiff = pbe_pkg::round30(diff);
  assign rprod = pbe_pkg::round30(prod);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r[0] <= '0;
      cam_r[1] <= '0;
      cam_r[2] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pbe_pkg::CFG_CAM_X: cam_r[0] <= cfg_data;
        pbe_pkg::CFG_CAM_Y: cam_r[1] <= cfg_data;
        pbe_pkg::CFG_CAM_Z: cam_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // store write port: clearing pass, dead slot, finished quad
  logic          st_we, st_vld_we, st_vld_d;
  logic [AW-1:0] st_addr;
  logic          quad_done;
  assign quad_done = (state_r == S_EMIT) && out_ready && (corner_r == 2'd3);
  always_comb begin
    st_we     = 1'b0;
    st_vld_we = 1'b0;
    st_vld_d  = 1'b0;
    st_addr   = addr_r;
    if (state_r == S_CLEAR) begin
      st_vld_we = 1'b1;
      st_addr   = clr_r;
    end else if (in_acc && !in_alive && in_pool) begin
      st_vld_we = 1'b1;
      st_addr   = in_addr;
    end else if (quad_done && in_pool_r) begin
      st_we     = 1'b1;
      st_vld_we = 1'b1;
      st_vld_d  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_vld_we) vld_mem[st_addr] <= st_vld_d;
    if (st_we) begin
      px_mem[st_addr] <= pos_r[0];
      py_mem[st_addr] <= pos_r[1];
      pz_mem[st_addr] <= pos_r[2];
    end
    if (in_acc) begin
      vrd_r    <= vld_mem[in_addr];
      prd_r[0] <= px_mem[in_addr];
      prd_r[1] <= py_mem[in_addr];
      prd_r[2] <= pz_mem[in_addr];
    end
  end

  // request latch and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r    <= in_addr;
      in_pool_r <= in_pool;
      pos_r[0]  <= in_center_x;
      pos_r[1]  <= in_center_y;
      pos_r[2]  <= in_center_z;
      size_r    <= in_half_size;
      col_r[0]  <= in_color_r;
      col_r[1]  <= in_color_g;
      col_r[2]  <= in_color_b;
      col_r[3]  <= in_color_a;
    end
    if (state_r == S_WF && u_rsp.done) begin
      f_r[0] <= uo_x;
      f_r[1] <= uo_y;
      f_r[2] <= uo_z;
    end
    if (state_r == S_WR && u_rsp.done) begin
      r_r[0] <= uo_x;
      r_r[1] <= uo_y;
      r_r[2] <= uo_z;
    end
    if (state_r == S_HINT) begin
      acc_r <= step_r[0] ? (acc_r + prod) : prod;
    end
    if (state_r == S_MUL) begin
      if (step_r < 4'd6) begin
        if (!step_r[0]) acc_r <= prod;
      end
      case (step_r)
        4'd1:    up_r[0] <= rdiff[31:0];
        4'd3:    up_r[1] <= rdiff[31:0];
        4'd5:    up_r[2] <= rdiff[31:0];
        4'd6:    re_r[0] <= rprod[32:0];
        4'd7:    re_r[1] <= rprod[32:0];
        4'd8:    re_r[2] <= rprod[32:0];
        4'd9:    ue_r[0] <= rprod[32:0];
        4'd10:   ue_r[1] <= rprod[32:0];
        4'd11:   ue_r[2] <= rprod[32:0];
        default: ;
      endcase
      // missing previous center takes the current one
      prv_r[0] <= (in_pool_r && vrd_r) ? prd_r[0] : pos_r[0];
      prv_r[1] <= (in_pool_r && vrd_r) ? prd_r[1] : pos_r[1];
      prv_r[2] <= (in_pool_r && vrd_r) ? prd_r[2] : pos_r[2];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      quads_r  <= '0;
      hint_z_r <= 1'b0;
      step_r   <= '0;
      corner_r <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(pbe_pkg::POOL_SLOTS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            quads_r <= q_eff;
            if (in_alive && (q_eff < QW'(pbe_pkg::QUAD_LIMIT))) state_r <= S_FWD;
          end
        end
        S_FWD: state_r <= S_WF;
        S_WF: begin
          if (u_rsp.done) begin
            if (u_rsp.ok) begin
              state_r  <= S_HINT;
              hint_z_r <= 1'b0;
              step_r   <= '0;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_HINT: begin
          if (step_r[0]) state_r <= S_HCHK;
          step_r <= step_r + 4'd1;
        end
        // hint length check, fall back from +Y to +Z
        S_HCHK: begin
          step_r <= '0;
          if (64'(acc_r) < pbe_pkg::RIGHT_EPS_Q60) begin
            if (hint_z_r) begin
              state_r <= S_IDLE;
            end else begin
              hint_z_r <= 1'b1;
              state_r  <= S_HINT;
            end
          end else begin
            state_r <= S_RST;
          end
        end
        S_RST: state_r <= S_WR;
        S_WR: begin
          if (u_rsp.done) begin
            state_r <= u_rsp.ok ? S_MUL : S_IDLE;
            step_r  <= '0;
          end
        end
        S_MUL: begin
          step_r <= step_r + 4'd1;
          if (step_r == 4'd11) begin
            state_r  <= S_EMIT;
            corner_r <= '0;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            corner_r <= corner_r + 2'd1;
            if (corner_r == 2'd3) begin
              state_r <= S_IDLE;
              quads_r <= quads_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // corner offsets and saturated sums
  logic sr_pos, su_pos;
  logic signed [35:0] off [3];
  assign sr_pos = (corner_r == 2'd1) || (corner_r == 2'd2);
  assign su_pos = corner_r[1];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off[i] = (sr_pos ? 36'(re_r[i]) : -36'(re_r[i]))
             + (su_pos ? 36'(ue_r[i]) : -36'(ue_r[i]));
    end
  end

  assign out_vert_x    = pbe_pkg::sat32(36'($signed(pos_r[0])) + off[0]);
  assign out_vert_y    = pbe_pkg::sat32(36'($signed(pos_r[1])) + off[1]);
  assign out_vert_z    = pbe_pkg::sat32(36'($signed(pos_r[2])) + off[2]);
  assign out_prev_x    = pbe_pkg::sat32(36'($signed(prv_r[0])) + off[0]);
  assign out_prev_y    = pbe_pkg::sat32(36'($signed(prv_r[1])) + off[1]);
  assign out_prev_z    = pbe_pkg::sat32(36'($signed(prv_r[2])) + off[2]);
  assign out_corner    = corner_r;
  assign out_out_r     = col_r[0];
  assign out_out_g     = col_r[1];
  assign out_out_b     = col_r[2];
  assign out_out_a     = col_r[3];
  assign out_quad_last = (corner_r == 2'd3);

`ifndef SYNTHESIS
  // no new request while corners are pending
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("request taken during corner output");
  // quad count never passes the frame limit
  assert property (@(posedge clk) disable iff (!rst_n)
    quads_r <= QW'(pbe_pkg::QUAD_LIMIT))
    else $error("quad count over limit");
  // the last corner ends the quad
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_quad_last) |=> !out_valid)
    else $error("corner after last");
  // normalizer results arrive only while waiting for them
  assert property (@(posedge clk) disable iff (!rst_n)
    u_rsp.done |-> (state_r == S_WF || state_r == S_WR))
    else $error("unexpected normalizer result");
`endif

endmodule
